@@ rtl/chained_hash_table_top_assert.svh @@
// Assertion macros for the chained hash table.
`ifndef CHAINED_HASH_TABLE_TOP_ASSERT_SVH
`define CHAINED_HASH_TABLE_TOP_ASSERT_SVH
`ifndef SYNTHESIS
`define CHT_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define CHT_ASSERT_NORST(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define CHT_ASSERT(label, clk, rst_n, prop, msg)
`define CHT_ASSERT_NORST(label, clk, prop, msg)
`endif
`endif

@@ rtl/cht_pkg.sv @@
// Shared types and constants of the chained hash table.
package cht_pkg;
  localparam int BUCKETS_MAX = 64;
  localparam int DEPTH       = 8;
  localparam int KEY_W       = 31;
  localparam int BKT_W       = $clog2(BUCKETS_MAX);
  localparam int POS_W       = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int FILL_W      = $clog2(DEPTH + 1);
  localparam int ADDR_W      = $clog2(BUCKETS_MAX * DEPTH);
  localparam int CNT_W       = 7;

  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_DELETE = 2'd1;
  localparam logic [1:0] OP_SEARCH = 2'd2;
  // The spare code is handled as a search.
  localparam logic [1:0] OP_SPARE  = 2'd3;

  localparam logic [2:0] ST_INSERTED  = 3'd0;
  localparam logic [2:0] ST_FULL      = 3'd1;
  localparam logic [2:0] ST_DELETED   = 3'd2;
  localparam logic [2:0] ST_DEL_FAIL  = 3'd3;
  localparam logic [2:0] ST_FOUND     = 3'd4;
  localparam logic [2:0] ST_NOT_FOUND = 3'd5;

  typedef struct packed {
    logic [1:0]       op;
    logic [KEY_W-1:0] key;
  } req_t;

  typedef struct packed {
    logic [2:0] status;
    logic [5:0] bucket_index;
    logic [2:0] position;
  } rsp_t;
endpackage

@@ rtl/cht_stream_if.sv @@
// Valid/ready channel carrying one payload beat.
interface cht_stream_if #(parameter type T = logic);
  logic valid;
  logic ready;
  T     payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

@@ rtl/cht_ram.sv @@
// Generic single-port RAM with a registered read.
module cht_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end
endmodule

@@ rtl/chained_hash_table_top.sv @@
// Top level of the chained hash table: modulo unit, bucket sequencer, entry and fill RAMs.
//
//   channel   dir  payload                           handshake
//   req       in   op, key                           valid/ready
//   rsp       out  status, bucket_index, position    valid/ready
//   cfg       in   bucket_count                      write enable
//
// After reset a pass over every bucket clears the fill RAM while req.ready stays low.
// A beat passes through the bit-serial modulo and then fetches the bucket fill.
// Then a full insert answers at once, an insert walks the bucket up to its fill, a
// search reads up to the fill and a delete finds the key, then moves the later entries.
// A result waits in the output register; the next beat is taken the cycle after it leaves.
module chained_hash_table_top (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [6:0]           cfg_wdata_i,
  cht_stream_if.sink           req,
  cht_stream_if.source         rsp
);
  `include "chained_hash_table_top_assert.svh"

  typedef enum logic [8:0] {
    S_CLEAR = 9'b000000001,
    S_IDLE  = 9'b000000010,
    S_MOD   = 9'b000000100,
    S_FILL  = 9'b000001000,
    S_LOOK  = 9'b000010000,
    S_SCAN  = 9'b000100000,
    S_INS   = 9'b001000000,
    S_SHIFT = 9'b010000000,
    S_WRITE = 9'b100000000
  } state_e;

  state_e                     state_q;
  logic [cht_pkg::CNT_W-1:0]  cnt_q;
  logic [1:0]                 op_q;
  logic [cht_pkg::KEY_W-1:0]  key_q, shreg_q;
  logic [cht_pkg::CNT_W-1:0]  rem_q, nbk_q;
  logic [4:0]                 bitc_q;
  logic [cht_pkg::BKT_W-1:0]  clr_q;
  logic [cht_pkg::FILL_W-1:0] fill_q;
  logic [cht_pkg::POS_W:0]    idx_q;
  logic                       rd_pend_q;
  logic [cht_pkg::POS_W-1:0]  pos_q;
  cht_pkg::rsp_t              rsp_q;
  logic                       rsp_valid_q;

  logic                       ram_we;
  logic [cht_pkg::ADDR_W-1:0] ram_addr;
  logic [cht_pkg::KEY_W-1:0]  ram_wdata, ram_rdata;
  logic                       fill_we;
  logic [cht_pkg::BKT_W-1:0]  fill_addr;
  logic [cht_pkg::FILL_W-1:0] fill_wdata, fill_rdata;
  logic [cht_pkg::BKT_W-1:0]  bkt;
  logic [cht_pkg::CNT_W:0]    rem_sh;
  logic                       key_hit;
  logic                       idx_lt_fill;
  logic                       ins_last;

  cht_ram #(.WIDTH(cht_pkg::KEY_W), .DEPTH(cht_pkg::BUCKETS_MAX * cht_pkg::DEPTH)) u_ram (
    .clk_i(clk_i), .we_i(ram_we), .addr_i(ram_addr), .wdata_i(ram_wdata),
    .rdata_o(ram_rdata)
  );

  cht_ram #(.WIDTH(cht_pkg::FILL_W), .DEPTH(cht_pkg::BUCKETS_MAX)) u_fill_ram (
    .clk_i(clk_i), .we_i(fill_we), .addr_i(fill_addr), .wdata_i(fill_wdata),
    .rdata_o(fill_rdata)
  );

  assign bkt         = rem_q[cht_pkg::BKT_W-1:0];
  assign rem_sh      = {rem_q, shreg_q[cht_pkg::KEY_W-1]};
  assign key_hit     = rd_pend_q && (ram_rdata == key_q);
  assign idx_lt_fill = idx_q < (cht_pkg::POS_W+1)'(fill_q);
  assign ins_last    = idx_q == (cht_pkg::POS_W+1)'(fill_q);
  assign req.ready   = (state_q == S_IDLE) && !rsp_valid_q;
  assign rsp.valid   = rsp_valid_q;
  assign rsp.payload = rsp_q;

  // An insert writes the carried key at each place and reads the old one back in the
  // same cycle; a delete reads an entry and writes it one place up in the next cycle.
  always_comb begin
    ram_we    = 1'b0;
    ram_addr  = {bkt, idx_q[cht_pkg::POS_W-1:0]};
    ram_wdata = ram_rdata;
    case (state_q)
      S_INS: begin
        ram_we = 1'b1;
        if (idx_q == '0) ram_wdata = key_q;
      end
      S_WRITE: begin
        ram_we   = 1'b1;
        ram_addr = {bkt, idx_q[cht_pkg::POS_W-1:0] - cht_pkg::POS_W'(1)};
      end
      default: ;
    endcase
  end

  always_comb begin
    fill_we    = 1'b0;
    fill_addr  = bkt;
    fill_wdata = '0;
    case (state_q)
      S_CLEAR: begin
        fill_we   = 1'b1;
        fill_addr = clr_q;
      end
      S_INS: begin
        if (ins_last) begin
          fill_we    = 1'b1;
          fill_wdata = fill_q + cht_pkg::FILL_W'(1);
        end
      end
      S_SHIFT: begin
        if (!idx_lt_fill) begin
          fill_we    = 1'b1;
          fill_wdata = fill_q - cht_pkg::FILL_W'(1);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      cnt_q       <= cht_pkg::CNT_W'(cht_pkg::BUCKETS_MAX);
      op_q        <= '0;
      key_q       <= '0;
      shreg_q     <= '0;
      rem_q       <= '0;
      nbk_q       <= '0;
      bitc_q      <= '0;
      clr_q       <= '0;
      fill_q      <= '0;
      idx_q       <= '0;
      rd_pend_q   <= 1'b0;
      pos_q       <= '0;
      rsp_q       <= '0;
      rsp_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) cnt_q <= cfg_wdata_i;
      if (rsp_valid_q && rsp.ready) rsp_valid_q <= 1'b0;
      case (state_q)
        S_CLEAR: begin
          clr_q <= clr_q + cht_pkg::BKT_W'(1);
          if (clr_q == cht_pkg::BKT_W'(cht_pkg::BUCKETS_MAX - 1)) state_q <= S_IDLE;
        end
        S_IDLE: begin
          if (req.valid && req.ready) begin
            op_q    <= req.payload.op;
            key_q   <= req.payload.key;
            shreg_q <= req.payload.key;
            rem_q   <= '0;
            bitc_q  <= 5'(cht_pkg::KEY_W - 1);
            if (cnt_q == '0) nbk_q <= cht_pkg::CNT_W'(1);
            else if (cnt_q > cht_pkg::CNT_W'(cht_pkg::BUCKETS_MAX)) begin
              nbk_q <= cht_pkg::CNT_W'(cht_pkg::BUCKETS_MAX);
            end else nbk_q <= cnt_q;
            state_q <= S_MOD;
          end
        end
        S_MOD: begin
          rem_q   <= (rem_sh >= {1'b0, nbk_q}) ? 7'(rem_sh - {1'b0, nbk_q}) : rem_sh[6:0];
          shreg_q <= shreg_q << 1;
          bitc_q  <= bitc_q - 5'd1;
          if (bitc_q == 5'd0) state_q <= S_FILL;
        end
        S_FILL: begin
          state_q <= S_LOOK;
        end
        S_LOOK: begin
          fill_q    <= fill_rdata;
          idx_q     <= '0;
          rd_pend_q <= 1'b0;
          if (op_q != cht_pkg::OP_INSERT) begin
            state_q <= S_SCAN;
          end else if (fill_rdata >= cht_pkg::FILL_W'(cht_pkg::DEPTH)) begin
            rsp_q       <= '{cht_pkg::ST_FULL, 6'(bkt), 3'd0};
            rsp_valid_q <= 1'b1;
            state_q     <= S_IDLE;
          end else begin
            state_q <= S_INS;
          end
        end
        S_SCAN: begin
          if (key_hit) begin
            rd_pend_q <= 1'b0;
            pos_q     <= idx_q[cht_pkg::POS_W-1:0] - cht_pkg::POS_W'(1);
            if (op_q == cht_pkg::OP_DELETE) begin
              state_q <= S_SHIFT;
            end else begin
              rsp_q       <= '{cht_pkg::ST_FOUND, 6'(bkt),
                               3'(idx_q[cht_pkg::POS_W-1:0] - cht_pkg::POS_W'(1))};
              rsp_valid_q <= 1'b1;
              state_q     <= S_IDLE;
            end
          end else if (idx_lt_fill) begin
            idx_q     <= idx_q + (cht_pkg::POS_W+1)'(1);
            rd_pend_q <= 1'b1;
          end else begin
            rsp_q       <= '{(op_q == cht_pkg::OP_DELETE) ? cht_pkg::ST_DEL_FAIL :
                             cht_pkg::ST_NOT_FOUND, 6'(bkt), 3'd0};
            rsp_valid_q <= 1'b1;
            state_q     <= S_IDLE;
          end
        end
        S_INS: begin
          if (ins_last) begin
            rsp_q       <= '{cht_pkg::ST_INSERTED, 6'(bkt), 3'd0};
            rsp_valid_q <= 1'b1;
            state_q     <= S_IDLE;
          end else begin
            idx_q <= idx_q + (cht_pkg::POS_W+1)'(1);
          end
        end
        S_SHIFT: begin
          if (!idx_lt_fill) begin
            rsp_q       <= '{cht_pkg::ST_DELETED, 6'(bkt), 3'(pos_q)};
            rsp_valid_q <= 1'b1;
            state_q     <= S_IDLE;
          end else begin
            state_q <= S_WRITE;
          end
        end
        S_WRITE: begin
          idx_q   <= idx_q + (cht_pkg::POS_W+1)'(1);
          state_q <= S_SHIFT;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  `CHT_ASSERT(a_rsp_hold, clk_i, rst_ni, rsp.valid && !rsp.ready |=> rsp.valid, "rsp dropped")
  `CHT_ASSERT(a_rsp_stable, clk_i, rst_ni, rsp.valid && !rsp.ready |=> $stable(rsp.payload), "rsp changed")
  `CHT_ASSERT(a_no_accept_busy, clk_i, rst_ni, req.ready |-> !rsp.valid, "accept while result waits")
  `CHT_ASSERT(a_write_state, clk_i, rst_ni, ram_we |-> (state_q == S_INS || state_q == S_WRITE), "stray RAM write")
  `CHT_ASSERT(a_fill_range, clk_i, rst_ni, state_q == S_LOOK |-> fill_rdata <= cht_pkg::FILL_W'(cht_pkg::DEPTH), "fill overflow")
endmodule
